// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	`ASSERT_CLK(label, clk, rst_n, !(expr))

`endif

// ===== hw/rtl/sjfs_pkg.sv =====
// ----------------------------------------------------------------------------
// sjfs_pkg
// types and constants of the shortest job first scheduler
// ----------------------------------------------------------------------------
package sjfs_pkg;

	localparam int TableDepth = 16;
	localparam int AddrW      = (TableDepth > 1) ? $clog2(TableDepth) : 1;
	localparam int CntW       = $clog2(TableDepth + 1);

	localparam int IdW    = 8;
	localparam int PrioW  = 4;
	localparam int BurstW = 16;
	localparam int KeyW   = BurstW + PrioW + IdW;
	localparam int TimeW  = 22;

	// key layout: burst | priority | id
	typedef logic [KeyW-1:0]  key_t;
	typedef logic [TimeW-1:0] time_t;
	typedef logic [AddrW-1:0] addr_t;
	typedef logic [CntW-1:0]  cnt_t;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_RD   = 6'b000010,
		ST_CMP  = 6'b000100,
		ST_ERD  = 6'b001000,
		ST_ELD  = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	typedef struct packed {
		logic gt;
		time_t sum;
	} unit_res_t;

	function automatic logic [BurstW-1:0] key_burst(key_t k);
		return k[KeyW-1 -: BurstW];
	endfunction

endpackage

// ===== hw/rtl/sjfs_ram.sv =====
// ----------------------------------------------------------------------------
// sjfs_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module sjfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/sjfs_unit.sv =====
// ----------------------------------------------------------------------------
// sjfs_unit
// shared key compare and time accumulate unit
// ----------------------------------------------------------------------------
module sjfs_unit
	import sjfs_pkg::*;
(
	input  key_t      entry,
	input  key_t      key,
	input  time_t     t_in,
	output unit_res_t res
);

	always_comb begin
		res.gt  = entry > key;
		res.sum = t_in + TimeW'(key_burst(entry));
	end

endmodule

// ===== hw/rtl/shortest_job_first_scheduler.sv =====
// ----------------------------------------------------------------------------
// shortest_job_first_scheduler
// sorted task table with batch schedule emission
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_stall   | task_id task_priority burst_length batch_end
//   out     | output    | out_valid / out_stall | sched_task_id turnaround_time waiting_time
//           |           |                       | tasks_dropped run_last
//
// a stored task shifts larger entries up one at a time through the single ram port,
// each shift a read then a compare, and is written at the table head or just behind
// the first entry not larger than it; a task that finds the table full is dropped
// a batch end then reads, loads and shows each result in turn, held by any output stall
// in_stall is high whenever the sequencer is not idle
// reset empties the table count; the table ram itself is not cleared
// ----------------------------------------------------------------------------
module shortest_job_first_scheduler
	import sjfs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  task_id,
	input  logic [3:0]  task_priority,
	input  logic [15:0] burst_length,
	input  logic        batch_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  sched_task_id,
	output logic [21:0] turnaround_time,
	output logic [21:0] waiting_time,
	output logic        tasks_dropped,
	output logic        run_last
);

	`include "assert_macros.svh"

	state_t    state_q;
	cnt_t      count_q;
	logic      overflow_q;
	logic      out_valid_q;
	key_t      key_q;
	logic      last_q;
	addr_t     pos_q;
	addr_t     k_q;
	time_t     t_q;
	logic [7:0] id_q;
	time_t     tat_q;
	time_t     wait_q;
	logic      drop_q;
	logic      rlast_q;

	logic      we;
	addr_t     waddr;
	key_t      wdata;
	addr_t     raddr;
	key_t      rdata;
	key_t      cmp_key;
	unit_res_t ures;
	logic      in_xfer;
	logic      out_xfer;

	sjfs_ram #(
		.WIDTH(KeyW),
		.DEPTH(TableDepth)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	sjfs_unit u_unit (
		.entry(rdata),
		.key  (cmp_key),
		.t_in (t_q),
		.res  (ures)
	);

	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid_q && !out_stall;
	assign cmp_key  = key_q;

	always_comb begin
		we    = 1'b0;
		waddr = pos_q;
		wdata = key_q;
		raddr = k_q;
		unique case (state_q)
			ST_RD: begin
				raddr = pos_q - addr_t'(1);
				if (pos_q == '0) begin
					we = 1'b1;
				end
			end
			ST_CMP: begin
				we = 1'b1;
				if (ures.gt) begin
					wdata = rdata;
				end
			end
			default: begin
				raddr = k_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			overflow_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (count_q < cnt_t'(TableDepth)) begin
							state_q <= ST_RD;
						end else begin
							overflow_q <= 1'b1;
							state_q    <= batch_end ? ST_ERD : ST_IDLE;
						end
					end
				end
				ST_RD: begin
					if (pos_q == '0) begin
						count_q <= count_q + cnt_t'(1);
						state_q <= last_q ? ST_ERD : ST_IDLE;
					end else begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (ures.gt) begin
						state_q <= ST_RD;
					end else begin
						count_q <= count_q + cnt_t'(1);
						state_q <= last_q ? ST_ERD : ST_IDLE;
					end
				end
				ST_ERD: begin
					state_q <= ST_ELD;
				end
				ST_ELD: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_OUT;
				end
				ST_OUT: begin
					if (out_xfer) begin
						out_valid_q <= 1'b0;
						if (rlast_q) begin
							count_q    <= '0;
							overflow_q <= 1'b0;
							state_q    <= ST_IDLE;
						end else begin
							state_q <= ST_ERD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					key_q  <= {burst_length, task_priority, task_id};
					last_q <= batch_end;
					pos_q  <= count_q[AddrW-1:0];
					k_q    <= '0;
					t_q    <= '0;
				end
			end
			ST_CMP: begin
				if (ures.gt) begin
					pos_q <= pos_q - addr_t'(1);
				end
			end
			ST_ELD: begin
				id_q    <= rdata[IdW-1:0];
				wait_q  <= t_q;
				tat_q   <= ures.sum;
				t_q     <= ures.sum;
				drop_q  <= overflow_q;
				rlast_q <= (cnt_t'(k_q) + cnt_t'(1)) == count_q;
			end
			ST_OUT: begin
				if (out_xfer) begin
					k_q <= k_q + addr_t'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid       = out_valid_q;
	assign sched_task_id   = id_q;
	assign turnaround_time = tat_q;
	assign waiting_time    = wait_q;
	assign tasks_dropped   = drop_q;
	assign run_last        = rlast_q;

	`ASSERT_CLK(a_out_blocks_in, clk, arst_n, out_valid_q |-> in_stall)
	`ASSERT_NEVER(a_count_range, clk, arst_n, count_q > cnt_t'(TableDepth))
	`ASSERT_CLK(a_load_shows, clk, arst_n, (state_q == ST_ELD) |=> out_valid_q)
	`ASSERT_CLK(a_insert_quiet, clk, arst_n,
		((state_q == ST_RD) || (state_q == ST_CMP)) |-> !out_valid_q)

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// feeds task batches to the shortest job first scheduler and checks every
// emitted schedule entry against a sorted-table predictor kept in lockstep
// ----------------------------------------------------------------------------
module testbench;

	import sjfs_pkg::*;

	localparam int WatchdogLimit = 4000;
	localparam int HoldCycles    = 300;
	localparam int RandomItems   = 245;

	typedef struct packed {
		logic [IdW-1:0]    id;
		logic [PrioW-1:0]  prio;
		logic [BurstW-1:0] burst;
		logic              ends_batch;
		logic              drain_first;
	} pending_task_t;

	typedef struct packed {
		logic [IdW-1:0] id;
		time_t          turnaround;
		time_t          waiting;
		logic           dropped;
		logic           closes_run;
	} sched_entry_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  task_id = '0;
	logic [3:0]  task_priority = '0;
	logic [15:0] burst_length = '0;
	logic        batch_end = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  sched_task_id;
	logic [21:0] turnaround_time;
	logic [21:0] waiting_time;
	logic        tasks_dropped;
	logic        run_last;

	pending_task_t task_q[$];
	sched_entry_t  schedule_q[$];

	// predictor state
	key_t held_keys [TableDepth];
	int   held_count = 0;
	logic batch_overflow = 1'b0;

	logic          expect_empty = 1'b1;
	logic          feed_done = 1'b0;
	logic          driver_go;
	pending_task_t next_task;
	int            issued = 0;
	int            out_xfers = 0;
	int            hold_left = 0;
	logic          hold_done = 1'b0;
	int            mismatch_count = 0;
	int            result_count = 0;
	int            quiet_cycles = 0;
	sched_entry_t  want;

	shortest_job_first_scheduler dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.task_id(task_id),
		.task_priority(task_priority),
		.burst_length(burst_length),
		.batch_end(batch_end),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sched_task_id(sched_task_id),
		.turnaround_time(turnaround_time),
		.waiting_time(waiting_time),
		.tasks_dropped(tasks_dropped),
		.run_last(run_last)
	);

	always #4 clk = ~clk;

	task automatic queue_task(input logic [IdW-1:0] id, input logic [PrioW-1:0] prio,
			input logic [BurstW-1:0] burst, input logic ends_batch, input logic drain_first);
		pending_task_t t;
		t.id = id;
		t.prio = prio;
		t.burst = burst;
		t.ends_batch = ends_batch;
		t.drain_first = drain_first;
		task_q.push_back(t);
	endtask

	// stable sorted insert, then the whole schedule on batch end
	task automatic admit_task(input logic [IdW-1:0] id, input logic [PrioW-1:0] prio,
			input logic [BurstW-1:0] burst, input logic ends_batch);
		key_t         key;
		int           pos;
		time_t        elapsed;
		sched_entry_t entry;
		key = {burst, prio, id};
		if (held_count < TableDepth) begin
			pos = held_count;
			while (pos > 0 && held_keys[pos-1] > key) begin
				held_keys[pos] = held_keys[pos-1];
				pos--;
			end
			held_keys[pos] = key;
			held_count++;
		end else begin
			batch_overflow = 1'b1;
		end
		if (ends_batch) begin
			elapsed = '0;
			for (int k = 0; k < held_count; k++) begin
				entry.id = held_keys[k][IdW-1:0];
				entry.waiting = elapsed;
				elapsed = elapsed + time_t'(held_keys[k][KeyW-1 -: BurstW]);
				entry.turnaround = elapsed;
				entry.dropped = batch_overflow;
				entry.closes_run = (k == held_count - 1);
				schedule_q.push_back(entry);
			end
			held_count = 0;
			batch_overflow = 1'b0;
		end
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			task_id <= '0;
			task_priority <= '0;
			burst_length <= '0;
			batch_end <= 1'b0;
			feed_done <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			driver_go = 1'b0;
			if (task_q.size() != 0) begin
				if (task_q[0].drain_first)
					driver_go = !in_valid && expect_empty;
				else
					driver_go = (issued >= 120 && issued < 180) || $urandom_range(99) >= 9;
			end
			if (driver_go) begin
				next_task = task_q.pop_front();
				task_id <= next_task.id;
				task_priority <= next_task.prio;
				burst_length <= next_task.burst;
				batch_end <= next_task.ends_batch;
				issued <= issued + 1;
			end
			in_valid <= driver_go;
			feed_done <= !driver_go && task_q.size() == 0;
		end
	end

	// receiver stall, with one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall)
				out_xfers <= out_xfers + 1;
			if (hold_left != 0) begin
				out_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else if (out_xfers >= 60 && !hold_done) begin
				out_stall <= 1'b1;
				hold_left <= HoldCycles;
				hold_done <= 1'b1;
			end else if (out_xfers >= 100 && out_xfers < 170) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= $urandom_range(99) < 9;
			end
		end
	end

	// checks results first, then predicts for the accepted task
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count = 0;
			batch_overflow = 1'b0;
			expect_empty <= 1'b1;
		end else begin
			if (out_valid && !out_stall) begin
				result_count++;
				if (schedule_q.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("result %0d unexpected: id %0d tat %0d wait %0d drop %b last %b",
							result_count, sched_task_id, turnaround_time, waiting_time,
							tasks_dropped, run_last);
				end else begin
					want = schedule_q.pop_front();
					if (sched_task_id !== want.id || turnaround_time !== want.turnaround ||
							waiting_time !== want.waiting || tasks_dropped !== want.dropped ||
							run_last !== want.closes_run) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display({"result %0d: expected id %0d tat %0d wait %0d drop %b",
								" last %b, got id %0d tat %0d wait %0d drop %b last %b"},
								result_count, want.id, want.turnaround, want.waiting,
								want.dropped, want.closes_run, sched_task_id,
								turnaround_time, waiting_time, tasks_dropped, run_last);
					end
				end
			end
			if (in_valid && !in_stall)
				admit_task(task_id, task_priority, burst_length, batch_end);
			expect_empty <= schedule_q.size() == 0;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WatchdogLimit) begin
			$display("no transfer for %0d cycles", quiet_cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int   random_total;
		int   batch_len;
		int   pick;
		logic narrow;
		random_total = 0;

		// single-task batches at the field extremes, second after a full drain
		queue_task(8'd255, 4'd15, 16'hFFFF, 1'b1, 1'b0);
		queue_task(8'd0, 4'd0, 16'd0, 1'b1, 1'b1);
		// equal bursts: priority then id decide, identical keys keep order
		queue_task(8'd7, 4'd3, 16'd100, 1'b0, 1'b0);
		queue_task(8'd7, 4'd3, 16'd100, 1'b0, 1'b0);
		queue_task(8'd5, 4'd3, 16'd100, 1'b0, 1'b0);
		queue_task(8'd9, 4'd2, 16'd100, 1'b0, 1'b0);
		queue_task(8'd1, 4'd10, 16'd50, 1'b1, 1'b0);
		// table full, overflowing task ends the batch
		for (int i = 0; i < TableDepth + 2; i++)
			queue_task(8'(255 - i), 4'(i), (i % 3 == 0) ? 16'hFFFF : 16'(65535 - 97 * i),
				i == TableDepth + 1, 1'b0);

		while (random_total < RandomItems) begin
			pick = $urandom_range(99);
			if (pick < 10)
				batch_len = $urandom_range(TableDepth + 6, TableDepth + 1);
			else if (pick < 20)
				batch_len = TableDepth;
			else
				batch_len = $urandom_range(12, 1);
			narrow = $urandom_range(3) == 0;
			for (int n = 0; n < batch_len; n++)
				queue_task(narrow ? 8'($urandom_range(3)) : 8'($urandom_range(255)),
					narrow ? 4'($urandom_range(2)) : 4'($urandom_range(15)),
					narrow ? 16'($urandom_range(2)) : ($urandom_range(3) == 0) ?
						16'(65535 - $urandom_range(15)) : 16'($urandom_range(65535)),
					n == batch_len - 1, n == 0 && $urandom_range(9) == 0);
			random_total += batch_len;
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (!(feed_done && expect_empty))
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatch_count == 0 && schedule_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			if (schedule_q.size() != 0)
				$display("%0d results never arrived", schedule_q.size());
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ===== shortest_job_first_scheduler.f =====
+incdir+hw/rtl
hw/rtl/sjfs_pkg.sv
hw/rtl/sjfs_ram.sv
hw/rtl/sjfs_unit.sv
hw/rtl/shortest_job_first_scheduler.sv
verif/testbench.sv
